// ----- design/rsa_mexp_pkg.sv -----
package rsa_mexp_pkg;

    // Fixed widths of the configuration registers and the item fields.
    localparam int CFG_W   = 32;
    localparam int IDX_W   = 2;
    localparam int FUNC_W  = 1;
    localparam int MSG_W   = 32;
    localparam int RES_W   = 32;

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] REG_MODULUS          = 2'd0;
    localparam logic [IDX_W-1:0] REG_PUBLIC_EXPONENT  = 2'd1;
    localparam logic [IDX_W-1:0] REG_PRIVATE_EXPONENT = 2'd2;

    // Operation codes of the func field.
    localparam logic [FUNC_W-1:0] FUNC_ENCRYPT = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_DECRYPT = 1'b1;

    // Operand selection for the shared modular multiplier.
    typedef logic [1:0] mm_sel_t;
    localparam mm_sel_t SEL_BASE   = 2'd0;
    localparam mm_sel_t SEL_ACC_SQ = 2'd1;
    localparam mm_sel_t SEL_SQ_SQ  = 2'd2;

    typedef struct packed {
        logic    load;
        logic    mm_start;
        mm_sel_t mm_sel;
        logic    mm_step;
        logic    wr_sq;
        logic    wr_acc;
        logic    exp_shift;
        logic    res_load;
    } dp_cmd_t;

    typedef struct packed {
        logic m_le1;
        logic exp_lsb;
        logic exp_zero;
    } dp_status_t;

endpackage

// ----- design/rsa_mexp_in_if.sv -----
interface rsa_mexp_in_if;
    import rsa_mexp_pkg::*;

    logic             valid;
    logic             ready;
    logic [FUNC_W-1:0] func;
    logic [MSG_W-1:0] message_value;

    modport source (output valid, output func, output message_value, input ready);
    modport sink (input valid, input func, input message_value, output ready);
endinterface

// ----- design/rsa_mexp_out_if.sv -----
interface rsa_mexp_out_if;
    import rsa_mexp_pkg::*;

    logic             valid;
    logic             ready;
    logic [RES_W-1:0] result_value;

    modport source (output valid, output result_value, input ready);
    modport sink (input valid, input result_value, output ready);
endinterface

// ----- design/rsa_mexp_ctrl.sv -----
module rsa_mexp_ctrl #(
    parameter int WIDTH = 32
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    output logic                      out_valid,
    input  logic                      out_ready,
    input  rsa_mexp_pkg::dp_status_t  status,
    output rsa_mexp_pkg::dp_cmd_t     cmd
);
    import rsa_mexp_pkg::*;

    localparam int CNT_W = $clog2(WIDTH);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WIDTH - 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RED  = 3'd1;
    localparam logic [2:0] ST_BIT  = 3'd2;
    localparam logic [2:0] ST_MACC = 3'd3;
    localparam logic [2:0] ST_MSQ  = 3'd4;
    localparam logic [2:0] ST_FIN  = 3'd5;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic             last_step;

    assign last_step = (cnt_reg == CNT_LAST);
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (status.m_le1)
                    begin
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        // Reduce the base first: base * 1 through the multiplier.
                        cmd.mm_start = 1'b1;
                        cmd.mm_sel   = SEL_BASE;
                        cnt_next     = '0;
                        state_next   = ST_RED;
                    end
                end
            end
            ST_RED:
            begin
                cmd.mm_step = 1'b1;
                cnt_next    = cnt_reg + CNT_W'(1);
                if (last_step)
                begin
                    cmd.wr_sq  = 1'b1;
                    state_next = ST_BIT;
                end
            end
            ST_BIT:
            begin
                cnt_next = '0;
                if (status.exp_zero)
                begin
                    state_next = ST_FIN;
                end
                else if (status.exp_lsb)
                begin
                    cmd.mm_start = 1'b1;
                    cmd.mm_sel   = SEL_ACC_SQ;
                    state_next   = ST_MACC;
                end
                else
                begin
                    cmd.mm_start = 1'b1;
                    cmd.mm_sel   = SEL_SQ_SQ;
                    state_next   = ST_MSQ;
                end
            end
            ST_MACC:
            begin
                cmd.mm_step = 1'b1;
                cnt_next    = cnt_reg + CNT_W'(1);
                if (last_step)
                begin
                    // The square reads only sq, so it may start as acc is written.
                    cmd.wr_acc   = 1'b1;
                    cmd.mm_start = 1'b1;
                    cmd.mm_sel   = SEL_SQ_SQ;
                    cnt_next     = '0;
                    state_next   = ST_MSQ;
                end
            end
            ST_MSQ:
            begin
                cmd.mm_step = 1'b1;
                cnt_next    = cnt_reg + CNT_W'(1);
                if (last_step)
                begin
                    cmd.wr_sq     = 1'b1;
                    cmd.exp_shift = 1'b1;
                    state_next    = ST_BIT;
                end
            end
            ST_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.res_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- design/rsa_mexp_dp.sv -----
module rsa_mexp_dp #(
    parameter int WIDTH = 32
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_we,
    input  logic [rsa_mexp_pkg::IDX_W-1:0]          cfg_index,
    input  logic [rsa_mexp_pkg::CFG_W-1:0]          cfg_data,
    input  logic [rsa_mexp_pkg::FUNC_W-1:0]         in_func,
    input  logic [rsa_mexp_pkg::MSG_W-1:0]          in_message,
    input  rsa_mexp_pkg::dp_cmd_t                   cmd,
    output rsa_mexp_pkg::dp_status_t                status,
    output logic [rsa_mexp_pkg::RES_W-1:0]          result_value
);
    import rsa_mexp_pkg::*;

    localparam int T_W = WIDTH + 2;

    logic [WIDTH-1:0] mod_reg, pub_reg, priv_reg;
    logic [WIDTH-1:0] exp_reg, acc_reg, sq_reg;
    logic [WIDTH-1:0] mm_a_reg, mm_b_reg, mm_p_reg;
    logic [WIDTH-1:0] res_reg;

    logic [WIDTH+CFG_W-1:0] cfg_ext, msg_ext, res_ext;
    logic [WIDTH-1:0]       cfg_val, msg_val;

    logic [WIDTH-1:0] addend, p_next;
    logic [T_W-1:0]   t_sum, m1_ext, m2_ext, t_sub1, t_sub2;

    // Register and message values are taken modulo 2^WIDTH.
    assign cfg_ext = {{WIDTH{1'b0}}, cfg_data};
    assign cfg_val = cfg_ext[WIDTH-1:0];
    assign msg_ext = {{(WIDTH + CFG_W - MSG_W){1'b0}}, in_message};
    assign msg_val = msg_ext[WIDTH-1:0];
    assign res_ext = {{CFG_W{1'b0}}, res_reg};
    assign result_value = res_ext[RES_W-1:0];

    assign status.m_le1    = (mod_reg[WIDTH-1:1] == '0);
    assign status.exp_lsb  = exp_reg[0];
    assign status.exp_zero = (exp_reg == '0);

    // One multiplier bit per step: p = (2p + b_msb * a) mod m, with 2p + a < 3m.
    assign addend = mm_b_reg[WIDTH-1] ? mm_a_reg : '0;
    assign t_sum  = {1'b0, mm_p_reg, 1'b0} + {2'b00, addend};
    assign m1_ext = {2'b00, mod_reg};
    assign m2_ext = {1'b0, mod_reg, 1'b0};
    assign t_sub1 = t_sum - m1_ext;
    assign t_sub2 = t_sum - m2_ext;

    always_comb
    begin
        if (t_sum >= m2_ext)
        begin
            p_next = t_sub2[WIDTH-1:0];
        end
        else if (t_sum >= m1_ext)
        begin
            p_next = t_sub1[WIDTH-1:0];
        end
        else
        begin
            p_next = t_sum[WIDTH-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mod_reg  <= WIDTH'(1);
            pub_reg  <= WIDTH'(3);
            priv_reg <= WIDTH'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MODULUS:          mod_reg  <= cfg_val;
                REG_PUBLIC_EXPONENT:  pub_reg  <= cfg_val;
                REG_PRIVATE_EXPONENT: priv_reg <= cfg_val;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            acc_reg <= WIDTH'(1);
            exp_reg <= (in_func == FUNC_DECRYPT) ? priv_reg : pub_reg;
        end
        else
        begin
            if (cmd.wr_acc)
            begin
                acc_reg <= p_next;
            end
            if (cmd.exp_shift)
            begin
                exp_reg <= exp_reg >> 1;
            end
        end

        if (cmd.wr_sq)
        begin
            sq_reg <= p_next;
        end

        if (cmd.mm_start)
        begin
            mm_p_reg <= '0;
            case (cmd.mm_sel)
                SEL_BASE:
                begin
                    mm_a_reg <= WIDTH'(1);
                    mm_b_reg <= msg_val;
                end
                SEL_ACC_SQ:
                begin
                    mm_a_reg <= acc_reg;
                    mm_b_reg <= sq_reg;
                end
                default:
                begin
                    mm_a_reg <= sq_reg;
                    mm_b_reg <= sq_reg;
                end
            endcase
        end
        else if (cmd.mm_step)
        begin
            mm_p_reg <= p_next;
            mm_b_reg <= mm_b_reg << 1;
        end

        if (cmd.res_load)
        begin
            res_reg <= status.m_le1 ? '0 : acc_reg;
        end
    end

endmodule

// ----- design/rsa_modular_exponentiation_unit.sv -----
// Modular exponentiation: each item returns message_value raised to the public
// exponent (func 0) or the private exponent (func 1), modulo the modulus register,
// with the base reduced first; a modulus of one gives 0. One item is worked on at
// a time, and the next item is taken while a finished result waits at the output.
// All work runs through one shared shift-add modular multiplier that handles one
// multiplier bit per cycle. Each exponent bit up to the highest set one costs a
// squaring, and each set bit also a multiply into the accumulator. With a modulus
// of zero or one an item skips the multiplier. The user must see that registers
// are written only while the block is idle; the block itself does not enforce this.
module rsa_modular_exponentiation_unit #(
    parameter int WIDTH = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [rsa_mexp_pkg::IDX_W-1:0]    cfg_index,
    input  logic [rsa_mexp_pkg::CFG_W-1:0]    cfg_data,
    rsa_mexp_in_if.sink                       in_ch,
    rsa_mexp_out_if.source                    out_ch
);
    import rsa_mexp_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;
    logic       in_acc;

    assign in_acc = in_ch.valid && in_ch.ready;

    rsa_mexp_ctrl #(
        .WIDTH (WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .status    (status),
        .cmd       (cmd)
    );

    rsa_mexp_dp #(
        .WIDTH (WIDTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_func      (in_ch.func),
        .in_message   (in_ch.message_value),
        .cmd          (cmd),
        .status       (status),
        .result_value (out_ch.result_value)
    );

    // An accepted item always leaves the block busy in the cycle after it is accepted.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !in_ch.ready)
        else $error("input taken again right after an item was accepted");

    // A new result only appears after the block has been busy.
    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_ch.valid) |-> !$past(in_ch.ready))
        else $error("result appeared without preceding work");

    // A result is loaded only from the finishing step, never during a multiply.
    a_load_not_during_mul: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_load |-> !cmd.mm_step && !cmd.mm_start)
        else $error("result loaded while the multiplier was busy");

endmodule

// ----- sim/rsa_mexp_checker.sv -----
module rsa_mexp_checker
    import rsa_mexp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    rsa_mexp_in_if           in_ch,
    rsa_mexp_out_if          out_ch,
    output int               mismatches,
    output int               pending,
    output int               checked
);

    logic [CFG_W-1:0] key_modulus;
    logic [CFG_W-1:0] key_public;
    logic [CFG_W-1:0] key_private;
    logic [RES_W-1:0] awaited_powers[$];
    logic [RES_W-1:0] wanted;

    // Exact base^exponent mod modulus; both factors stay below 2^32, so a
    // 64-bit product never overflows.
    function automatic logic [RES_W-1:0] power_mod(
        input logic [MSG_W-1:0] base,
        input logic [CFG_W-1:0] exponent,
        input logic [CFG_W-1:0] modulus
    );
        logic [63:0] wide_mod;
        logic [63:0] running;
        logic [63:0] square;
        if (modulus <= 1)
            return '0;
        wide_mod = {32'd0, modulus};
        square   = {32'd0, base} % wide_mod;
        running  = 64'd1;
        for (int i = 0; i < CFG_W; i++)
        begin
            if (exponent[i])
                running = (running * square) % wide_mod;
            square = (square * square) % wide_mod;
        end
        return running[RES_W-1:0];
    endfunction

    task automatic report_mismatch(
        input string            what,
        input logic [RES_W-1:0] want_v,
        input logic [RES_W-1:0] got_v
    );
        $display("MISMATCH at %0t: %s, expected %h, got %h", $time, what, want_v, got_v);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_modulus = 32'd1;
            key_public  = 32'd3;
            key_private = 32'd1;
            awaited_powers.delete();
            mismatches = 0;
            checked    = 0;
            pending   <= 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                checked++;
                if (awaited_powers.size() == 0)
                    report_mismatch("result with no item outstanding", '0,
                                    out_ch.result_value);
                else
                begin
                    wanted = awaited_powers.pop_front();
                    if (out_ch.result_value !== wanted)
                        report_mismatch("result_value", wanted, out_ch.result_value);
                end
            end
            if (in_ch.valid && in_ch.ready)
                awaited_powers.push_back(power_mod(in_ch.message_value,
                    (in_ch.func == FUNC_DECRYPT) ? key_private : key_public,
                    key_modulus));
            // Writes to an index with no register behind it are dropped.
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_MODULUS:          key_modulus = cfg_data;
                    REG_PUBLIC_EXPONENT:  key_public  = cfg_data;
                    REG_PRIVATE_EXPONENT: key_private = cfg_data;
                    default:              ;
                endcase
            end
            pending <= awaited_powers.size();
        end
    end

endmodule

// ----- sim/tb_rsa_modular_exponentiation_unit.sv -----
module tb_rsa_modular_exponentiation_unit;
    import rsa_mexp_pkg::*;

    localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int TAIL_CYCLES = 2200;
    localparam int KEY_ROUNDS  = 14;
    localparam int ROUND_ITEMS = 20;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;

    int mismatches;
    int pending;
    int checked;
    int items_sent;
    int keys_loaded;
    int cycle_count = 0;
    int send_idle_pct;
    int recv_idle_pct;
    logic [CFG_W-1:0] key_n;

    rsa_mexp_in_if  in_ch ();
    rsa_mexp_out_if out_ch ();

    rsa_modular_exponentiation_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    rsa_mexp_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .mismatches (mismatches),
        .pending    (pending),
        .checked    (checked)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Run stopped after %0d cycles with %0d results outstanding.",
                     cycle_count, pending);
            $display("end of test: mismatches");
            $finish;
        end
    end

    always @(posedge clk)
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);

    task automatic send_item(input logic [FUNC_W-1:0] func, input logic [MSG_W-1:0] msg);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.func          <= func;
        in_ch.message_value <= msg;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        items_sent++;
    endtask

    // Registers may only change once every item in flight has been returned.
    task automatic drain;
        in_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    task automatic load_key(input logic [CFG_W-1:0] n, input logic [CFG_W-1:0] e,
                            input logic [CFG_W-1:0] d);
        cfg_we    <= 1'b1;
        cfg_index <= REG_MODULUS;
        cfg_data  <= n;
        @(posedge clk);
        cfg_index <= REG_PUBLIC_EXPONENT;
        cfg_data  <= e;
        @(posedge clk);
        cfg_index <= REG_PRIVATE_EXPONENT;
        cfg_data  <= d;
        @(posedge clk);
        cfg_we <= 1'b0;
        key_n = n;
        keys_loaded++;
    endtask

    function automatic logic [CFG_W-1:0] pick_modulus();
        case ($urandom_range(9))
            0:       return 32'd0;
            1:       return 32'd1;
            2:       return 32'hFFFF_FFFF;
            3, 4:    return $urandom_range(65535, 2);
            default: return $urandom;
        endcase
    endfunction

    // Most exponents are short so that the run stays fast; a few use all bits.
    function automatic logic [CFG_W-1:0] pick_exponent();
        case ($urandom_range(9))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom;
            default: return $urandom & ((32'd1 << $urandom_range(16, 1)) - 32'd1);
        endcase
    endfunction

    function automatic logic [MSG_W-1:0] pick_message();
        case ($urandom_range(7))
            0:       return 32'd0;
            1:       return 32'd1;
            2:       return key_n - 32'd1;
            3:       return 32'hFFFF_FFFF;
            4:       return (key_n != 0) ? $urandom % key_n : $urandom;
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        rst_n               <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_index           <= REG_MODULUS;
        cfg_data            <= '0;
        in_ch.valid         <= 1'b0;
        in_ch.func          <= FUNC_ENCRYPT;
        in_ch.message_value <= '0;
        items_sent           = 0;
        keys_loaded          = 0;
        key_n                = 32'd1;
        send_idle_pct        = 29;
        recv_idle_pct        = 49;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A write to the unused index must leave the reset key in place.
        cfg_we    <= 1'b1;
        cfg_index <= REG_UNUSED;
        cfg_data  <= 32'd5;
        @(posedge clk);
        cfg_we <= 1'b0;
        send_item(FUNC_ENCRYPT, 32'd0);
        send_item(FUNC_DECRYPT, 32'hFFFF_FFFF);
        send_item(FUNC_ENCRYPT, 32'h1234_5678);
        drain();

        load_key(32'd0, 32'd3, 32'd1);
        send_item(FUNC_ENCRYPT, 32'd12345);
        send_item(FUNC_DECRYPT, 32'd0);
        drain();

        load_key(32'd3233, 32'd17, 32'd2753);
        send_item(FUNC_ENCRYPT, 32'd65);
        send_item(FUNC_DECRYPT, 32'd2790);
        send_item(FUNC_ENCRYPT, 32'd0);
        send_item(FUNC_DECRYPT, 32'd1);
        send_item(FUNC_ENCRYPT, 32'd3233);
        send_item(FUNC_DECRYPT, 32'hFFFF_FFFF);
        drain();

        // A zero public exponent gives one, even for a zero base; decrypt uses an all-ones exponent.
        load_key(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
        send_item(FUNC_ENCRYPT, 32'd0);
        send_item(FUNC_ENCRYPT, 32'hFFFF_FFFF);
        send_item(FUNC_DECRYPT, 32'hFFFF_FFFE);
        send_item(FUNC_DECRYPT, 32'h8000_0000);
        drain();

        load_key(32'd2, 32'hFFFF_FFFF, 32'd0);
        send_item(FUNC_ENCRYPT, 32'd3);
        send_item(FUNC_DECRYPT, 32'd0);
        send_item(FUNC_ENCRYPT, 32'd2);
        drain();

        load_key(32'hFFFF_FFFB, 32'hFFFF_FFFF, 32'd1);
        send_item(FUNC_ENCRYPT, $urandom);
        send_item(FUNC_DECRYPT, 32'hFFFF_FFFF);
        drain();

        for (int k = 0; k < KEY_ROUNDS; k++)
        begin
            if (k < 5)
            begin
                send_idle_pct = 29;
                recv_idle_pct = 49;
            end
            else if (k < 10)
            begin
                send_idle_pct = 49;
                recv_idle_pct = 29;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            load_key(pick_modulus(), pick_exponent(), pick_exponent());
            repeat (ROUND_ITEMS)
                send_item($urandom_range(1) ? FUNC_DECRYPT : FUNC_ENCRYPT, pick_message());
            drain();
        end

        // Give a stray extra result time to show up.
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Checked %0d results from %0d items across %0d keys, with and without stalls,",
                 checked, items_sent, keys_loaded);
        $display("including moduli of zero, one and all ones and zero and all-ones exponents.");
        if (mismatches == 0 && pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ----- sim.f -----
design/rsa_mexp_pkg.sv
design/rsa_mexp_in_if.sv
design/rsa_mexp_out_if.sv
design/rsa_mexp_ctrl.sv
design/rsa_mexp_dp.sv
design/rsa_modular_exponentiation_unit.sv
sim/rsa_mexp_checker.sv
sim/tb_rsa_modular_exponentiation_unit.sv
